// ===== hdl/lgcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgcs_pkg
// Shared codes, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lgcs_pkg;

    localparam int DefMaxPoints = 1024;
    localparam int DefMaxLabels = 64;

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_LOAD   = 3'd1;
    localparam logic [2:0] REQ_FINISH = 3'd2;
    localparam logic [2:0] REQ_INDEX  = 3'd3;
    localparam logic [2:0] REQ_ENTRY  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LBL_FULL = 2'd1;
    localparam logic [1:0] ST_PT_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;
    localparam logic [3:0] OP_CLEAR    = 4'd2;
    localparam logic [3:0] OP_ERR      = 4'd3;
    localparam logic [3:0] OP_NEXT     = 4'd4;
    localparam logic [3:0] OP_HIT      = 4'd5;
    localparam logic [3:0] OP_NEW      = 4'd6;
    localparam logic [3:0] OP_PFX_WR   = 4'd7;
    localparam logic [3:0] OP_SC_START = 4'd8;
    localparam logic [3:0] OP_SC_CLS   = 4'd9;
    localparam logic [3:0] OP_SC_WR    = 4'd10;
    localparam logic [3:0] OP_FIN      = 4'd11;
    localparam logic [3:0] OP_ENT_RD   = 4'd12;
    localparam logic [3:0] OP_IDX_OUT  = 4'd13;
    localparam logic [3:0] OP_ENT_OUT  = 4'd14;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       pts_full;
        logic       lbl_full;
        logic       lbl_end;
        logic       pt_end;
        logic       hit;
        logic       done;
        logic       pos_pt_ok;
        logic       pos_lbl_ok;
    } t_stat;

endpackage

// ===== hdl/lgcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lgcs_ctrl
// Sequencer: handshake, request dispatch, label scan, prefix and scatter walk.
// ----------------------------------------------------------------------------
module lgcs_ctrl
    import lgcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISP     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_PFX_RD   = 4'd4;
    localparam logic [3:0] S_PFX_WR   = 4'd5;
    localparam logic [3:0] S_SC_RD    = 4'd6;
    localparam logic [3:0] S_SC_CLS   = 4'd7;
    localparam logic [3:0] S_SC_WR    = 4'd8;
    localparam logic [3:0] S_IDX_WAIT = 4'd9;
    localparam logic [3:0] S_ENT_WAIT = 4'd10;
    localparam logic [3:0] S_RESP     = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_RESP);

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_stat.req == REQ_CLEAR) begin
                    o_cmd.op = OP_CLEAR;
                    n_state  = S_RESP;
                end else if (i_stat.req == REQ_LOAD) begin
                    if (i_stat.pts_full) begin
                        o_cmd.op     = OP_ERR;
                        o_cmd.status = ST_PT_FULL;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else if (i_stat.req == REQ_FINISH) begin
                    n_state = S_PFX_RD;
                end else if (i_stat.req == REQ_INDEX) begin
                    if (i_stat.done && i_stat.pos_pt_ok) begin
                        n_state = S_IDX_WAIT;
                    end else begin
                        o_cmd.op     = OP_ERR;
                        o_cmd.status = ST_RANGE;
                        n_state      = S_RESP;
                    end
                end else if (i_stat.req == REQ_ENTRY) begin
                    if (i_stat.done && i_stat.pos_lbl_ok) begin
                        o_cmd.op = OP_ENT_RD;
                        n_state  = S_ENT_WAIT;
                    end else begin
                        o_cmd.op     = OP_ERR;
                        o_cmd.status = ST_RANGE;
                        n_state      = S_RESP;
                    end
                end else begin
                    o_cmd.op     = OP_ERR;
                    o_cmd.status = ST_RANGE;
                    n_state      = S_RESP;
                end
            end
            S_SCAN_RD: begin
                if (i_stat.lbl_end) begin
                    if (i_stat.lbl_full) begin
                        o_cmd.op     = OP_ERR;
                        o_cmd.status = ST_LBL_FULL;
                    end else begin
                        o_cmd.op = OP_NEW;
                    end
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.op = OP_HIT;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_SCAN_RD;
                end
            end
            S_PFX_RD: begin
                if (i_stat.lbl_end) begin
                    o_cmd.op = OP_SC_START;
                    n_state  = S_SC_RD;
                end else begin
                    n_state = S_PFX_WR;
                end
            end
            S_PFX_WR: begin
                o_cmd.op = OP_PFX_WR;
                n_state  = S_PFX_RD;
            end
            S_SC_RD: begin
                if (i_stat.pt_end) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_SC_CLS;
                end
            end
            S_SC_CLS: begin
                o_cmd.op = OP_SC_CLS;
                n_state  = S_SC_WR;
            end
            S_SC_WR: begin
                o_cmd.op = OP_SC_WR;
                n_state  = S_SC_RD;
            end
            S_IDX_WAIT: begin
                o_cmd.op = OP_IDX_OUT;
                n_state  = S_RESP;
            end
            S_ENT_WAIT: begin
                o_cmd.op = OP_ENT_OUT;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/lgcs_dp.sv =====
// ----------------------------------------------------------------------------
// lgcs_dp
// Datapath: label, count, start, class, order and cursor memories, counters
// and result registers.
// ----------------------------------------------------------------------------
module lgcs_dp
    import lgcs_pkg::*;
#(
    parameter int MAX_POINTS = DefMaxPoints,
    parameter int MAX_LABELS = DefMaxLabels
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_label_bits,
    input  logic [9:0]  i_position,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [1:0]  o_status,
    output logic [5:0]  o_class_id,
    output logic        o_is_new,
    output logic [9:0]  o_point_index,
    output logic [63:0] o_label_value,
    output logic [10:0] o_label_count,
    output logic [10:0] o_label_start,
    output logic [6:0]  o_distinct_labels
);

    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int LCW  = $clog2(MAX_LABELS + 1);
    localparam int LAW  = $clog2(MAX_LABELS);
    localparam int IW   = (PCW > LCW) ? PCW : LCW;
    localparam int CMPW = (IW > 10) ? IW : 10;

    logic [63:0]    label_mem  [MAX_LABELS];
    logic [PCW-1:0] count_mem  [MAX_LABELS];
    logic [PCW-1:0] start_mem  [MAX_LABELS];
    logic [PCW-1:0] cursor_mem [MAX_LABELS];
    logic [LAW-1:0] class_mem  [MAX_POINTS];
    logic [PAW-1:0] order_mem  [MAX_POINTS];

    logic [2:0]     r_req;
    logic [63:0]    r_bits;
    logic [9:0]     r_pos;
    logic [PCW-1:0] r_pts;
    logic [LCW-1:0] r_lbls;
    logic           r_done;
    logic [IW-1:0]  r_idx;
    logic [PCW-1:0] r_run;

    logic [63:0]    r_lbl_rd;
    logic [PCW-1:0] r_cnt_rd;
    logic [PCW-1:0] r_start_rd;
    logic [PCW-1:0] r_cur_rd;
    logic [LAW-1:0] r_cls_rd;
    logic [PAW-1:0] r_ord_rd;
    logic [LAW-1:0] r_cls;

    logic [1:0]     r_status;
    logic [5:0]     r_class_id;
    logic           r_is_new;
    logic [9:0]     r_point_index;
    logic [63:0]    r_label_value;
    logic [10:0]    r_label_count;
    logic [10:0]    r_label_start;

    logic [LAW-1:0] tbl_addr;
    logic [LAW-1:0] idx_lbl;
    logic [PAW-1:0] idx_pt;

    assign idx_lbl  = r_idx[LAW-1:0];
    assign idx_pt   = r_idx[PAW-1:0];
    assign tbl_addr = (i_cmd.op == OP_ENT_RD) ? LAW'(r_pos) : idx_lbl;

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts  <= '0;
            r_lbls <= '0;
            r_done <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_CLEAR: begin
                    r_pts  <= '0;
                    r_lbls <= '0;
                    r_done <= 1'b0;
                end
                OP_HIT: begin
                    r_pts  <= r_pts + PCW'(1);
                    r_done <= 1'b0;
                end
                OP_NEW: begin
                    r_pts  <= r_pts + PCW'(1);
                    r_lbls <= r_lbls + LCW'(1);
                    r_done <= 1'b0;
                end
                OP_FIN: begin
                    r_done <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // working registers and memory writes
    always_ff @(posedge i_clk) begin
        r_lbl_rd   <= label_mem[tbl_addr];
        r_cnt_rd   <= count_mem[tbl_addr];
        r_start_rd <= start_mem[tbl_addr];
        r_cls_rd   <= class_mem[idx_pt];
        r_ord_rd   <= order_mem[PAW'(r_pos)];
        r_cur_rd   <= cursor_mem[r_cls_rd];
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_req  <= i_req_type;
                r_bits <= i_label_bits;
                r_pos  <= i_position;
                r_idx  <= '0;
                r_run  <= '0;
            end
            OP_NEXT: begin
                r_idx <= r_idx + IW'(1);
            end
            OP_HIT: begin
                count_mem[idx_lbl] <= r_cnt_rd + PCW'(1);
                class_mem[r_pts[PAW-1:0]] <= idx_lbl;
            end
            OP_NEW: begin
                label_mem[idx_lbl] <= r_bits;
                count_mem[idx_lbl] <= PCW'(1);
                class_mem[r_pts[PAW-1:0]] <= idx_lbl;
            end
            OP_PFX_WR: begin
                start_mem[idx_lbl]  <= r_run;
                cursor_mem[idx_lbl] <= r_run;
                r_run <= r_run + r_cnt_rd;
                r_idx <= r_idx + IW'(1);
            end
            OP_SC_START: begin
                r_idx <= '0;
            end
            OP_SC_CLS: begin
                r_cls <= r_cls_rd;
            end
            OP_SC_WR: begin
                order_mem[r_cur_rd[PAW-1:0]] <= idx_pt;
                cursor_mem[r_cls] <= r_cur_rd + PCW'(1);
                r_idx <= r_idx + IW'(1);
            end
            default: begin
            end
        endcase
    end

    // result registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CLEAR, OP_ERR, OP_FIN, OP_HIT, OP_NEW, OP_IDX_OUT, OP_ENT_OUT: begin
                r_status      <= i_cmd.status;
                r_class_id    <= '0;
                r_is_new      <= 1'b0;
                r_point_index <= '0;
                r_label_value <= '0;
                r_label_count <= '0;
                r_label_start <= '0;
                if (i_cmd.op == OP_HIT || i_cmd.op == OP_NEW) begin
                    r_class_id <= 6'(idx_lbl);
                    r_is_new   <= (i_cmd.op == OP_NEW);
                end
                if (i_cmd.op == OP_IDX_OUT) begin
                    r_point_index <= 10'(r_ord_rd);
                end
                if (i_cmd.op == OP_ENT_OUT) begin
                    r_class_id    <= 6'(r_pos);
                    r_label_value <= r_lbl_rd;
                    r_label_count <= 11'(r_cnt_rd);
                    r_label_start <= 11'(r_start_rd);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.req        = r_req;
    assign o_stat.pts_full   = (r_pts == PCW'(MAX_POINTS));
    assign o_stat.lbl_full   = (r_lbls == LCW'(MAX_LABELS));
    assign o_stat.lbl_end    = (r_idx == IW'(r_lbls));
    assign o_stat.pt_end     = (r_idx == IW'(r_pts));
    assign o_stat.hit        = (r_lbl_rd == r_bits);
    assign o_stat.done       = r_done;
    assign o_stat.pos_pt_ok  = (CMPW'(r_pos) < CMPW'(r_pts));
    assign o_stat.pos_lbl_ok = (CMPW'(r_pos) < CMPW'(r_lbls));

    assign o_status          = r_status;
    assign o_class_id        = r_class_id;
    assign o_is_new          = r_is_new;
    assign o_point_index     = r_point_index;
    assign o_label_value     = r_label_value;
    assign o_label_count     = r_label_count;
    assign o_label_start     = r_label_start;
    assign o_distinct_labels = 7'(r_lbls);

endmodule

// ===== hdl/label_group_counting_sort.sv =====
// ----------------------------------------------------------------------------
// label_group_counting_sort
// Groups point labels by first appearance and sorts point numbers by label.
//
// One request per input transaction (i_valid/o_ready), one result per
// request on the output transaction (o_valid/i_ready). One request is in
// flight at a time; o_ready is high only while the block is idle.
// Clear, point store full and out of range answer straight from dispatch; read
// index and read entry pass through a wait state first. A load compares the
// stored labels in order until a match, or adds a new label (or reports the
// table full) after the last one. Finish walks every label for the prefix
// sums, then scatters every point.
// The label table is walked one entry at a time through its single read
// port; the scatter reads each point's class, then its cursor, and then
// writes its order entry.
// A stalled receiver holds the result in the output registers until taken.
// Reset empties the set (zero points, zero labels, not grouped); memory
// contents are left as they are and are never used before being written.
// ----------------------------------------------------------------------------
module label_group_counting_sort
    import lgcs_pkg::*;
#(
    parameter int MAX_POINTS = DefMaxPoints,
    parameter int MAX_LABELS = DefMaxLabels
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_label_bits,
    input  logic [9:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_class_id,
    output logic        o_is_new,
    output logic [9:0]  o_point_index,
    output logic [63:0] o_label_value,
    output logic [10:0] o_label_count,
    output logic [10:0] o_label_start,
    output logic [6:0]  o_distinct_labels
);

    t_cmd  cmd;
    t_stat stat;

    lgcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lgcs_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_LABELS (MAX_LABELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_type        (i_req_type),
        .i_label_bits      (i_label_bits),
        .i_position        (i_position),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_class_id        (o_class_id),
        .o_is_new          (o_is_new),
        .o_point_index     (o_point_index),
        .o_label_value     (o_label_value),
        .o_label_count     (o_label_count),
        .o_label_start     (o_label_start),
        .o_distinct_labels (o_distinct_labels)
    );

endmodule

// ===== sim/tb_label_group_counting_sort.sv =====
// ----------------------------------------------------------------------------
// tb_label_group_counting_sort
// Randomized self-checking bench for the label grouping block: clears, loads,
// finish, reads and unused codes are driven, every result is compared with a built-in predictor.
// ----------------------------------------------------------------------------
module tb_label_group_counting_sort
    import lgcs_pkg::*;
;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  class_id;
        logic        is_new;
        logic [9:0]  point_index;
        logic [63:0] label_value;
        logic [10:0] label_count;
        logic [10:0] label_start;
        logic [6:0]  distinct_labels;
    } t_result;

    class grouping_scoreboard;
        logic [63:0] labels [64];
        int          counts [64];
        int          starts [64];
        int          point_cls [1024];
        int          order [1024];
        int          num_pts;
        int          num_lbls;
        bit          grouped;
        t_result     pending [$];
        int          errors;
        int          checked;

        function new();
            num_pts  = 0;
            num_lbls = 0;
            grouped  = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void note_request(logic [2:0] req, logic [63:0] bits, logic [9:0] pos);
            t_result r;
            int      j;
            int      run;
            int      cur [64];
            r = '0;
            case (req)
                REQ_CLEAR: begin
                    num_pts  = 0;
                    num_lbls = 0;
                    grouped  = 0;
                end
                REQ_LOAD: begin
                    j = 0;
                    while (j < num_lbls && labels[j] != bits) j++;
                    if (num_pts >= 1024) begin
                        r.status = ST_PT_FULL;
                    end else if (j >= num_lbls && num_lbls >= 64) begin
                        r.status = ST_LBL_FULL;
                    end else begin
                        if (j >= num_lbls) begin
                            labels[j] = bits;
                            counts[j] = 0;
                            num_lbls++;
                            r.is_new = 1'b1;
                        end
                        counts[j]++;
                        point_cls[num_pts] = j;
                        num_pts++;
                        grouped = 0;
                        r.class_id = j[5:0];
                    end
                end
                REQ_FINISH: begin
                    run = 0;
                    for (int i = 0; i < num_lbls; i++) begin
                        starts[i] = run;
                        cur[i] = run;
                        run += counts[i];
                    end
                    for (int i = 0; i < num_pts; i++) begin
                        order[cur[point_cls[i]]] = i;
                        cur[point_cls[i]]++;
                    end
                    grouped = 1;
                end
                REQ_INDEX: begin
                    if (!grouped || pos >= num_pts) r.status = ST_RANGE;
                    else r.point_index = order[pos][9:0];
                end
                REQ_ENTRY: begin
                    if (!grouped || pos >= num_lbls) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.class_id    = pos[5:0];
                        r.label_value = labels[pos];
                        r.label_count = counts[pos][10:0];
                        r.label_start = starts[pos][10:0];
                    end
                end
                default: r.status = ST_RANGE;
            endcase
            r.distinct_labels = num_lbls[6:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(t_result act);
            t_result exp;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", act);
                return;
            end
            exp = pending.pop_front();
            if (act !== exp) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch (st cls new idx val cnt start n)");
                    $display("  exp %0d %0d %0d %0d %h %0d %0d %0d",
                             exp.status, exp.class_id, exp.is_new, exp.point_index,
                             exp.label_value, exp.label_count, exp.label_start,
                             exp.distinct_labels);
                    $display("  act %0d %0d %0d %0d %h %0d %0d %0d",
                             act.status, act.class_id, act.is_new, act.point_index,
                             act.label_value, act.label_count, act.label_start,
                             act.distinct_labels);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_req_type;
    logic [63:0] i_label_bits;
    logic [9:0]  i_position;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [5:0]  o_class_id;
    logic        o_is_new;
    logic [9:0]  o_point_index;
    logic [63:0] o_label_value;
    logic [10:0] o_label_count;
    logic [10:0] o_label_start;
    logic [6:0]  o_distinct_labels;

    grouping_scoreboard sb;
    bit          quiet_phase;
    int          idle_cycles;
    int          n_sent;
    logic [63:0] label_pool [16];

    label_group_counting_sort uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 12);
    endfunction

    task automatic send(logic [2:0] req, logic [63:0] bits, logic [9:0] pos);
        while (idle_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_label_bits <= bits;
        i_position   <= pos;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        sb.note_request(req, bits, pos);
        n_sent++;
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function logic [63:0] pick_label(int nlab);
        return label_pool[$urandom_range(nlab - 1)];
    endfunction

    task automatic run_set(int npts, int nlab, int nreads);
        send(REQ_CLEAR, rand64(), 10'($urandom));
        for (int i = 0; i < npts; i++) send(REQ_LOAD, pick_label(nlab), 10'($urandom));
        if ($urandom_range(9) == 0) send(REQ_INDEX, '0, '0);
        send(REQ_FINISH, rand64(), '0);
        for (int i = 0; i < nreads; i++) begin
            if ($urandom_range(1))
                send(REQ_INDEX, '0, 10'($urandom_range(npts)));
            else
                send(REQ_ENTRY, '0, 10'($urandom_range(nlab)));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_status, o_class_id, o_is_new, o_point_index, o_label_value,
                             o_label_count, o_label_start, o_distinct_labels});
        if (i_rst_n) i_ready <= !idle_now();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_req_type = REQ_CLEAR;
        i_label_bits = '0;
        i_position = '0;
        quiet_phase = 1'b0;
        n_sent = 0;
        label_pool[0] = '0;
        label_pool[1] = '1;
        for (int i = 2; i < 16; i++) label_pool[i] = rand64();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty set, reads before finish, unused codes, extremes
        send(REQ_INDEX, '0, '0);
        send(REQ_ENTRY, '0, '0);
        send(REQ_FINISH, '0, '0);
        send(REQ_ENTRY, '0, '0);
        send(3'd5, '1, '1);
        send(3'd6, '0, '0);
        send(3'd7, '1, '1);
        send(REQ_LOAD, '0, '0);
        send(REQ_LOAD, '1, '1);
        send(REQ_LOAD, '0, '0);
        send(REQ_FINISH, '0, '0);
        send(REQ_INDEX, '0, 10'd2);
        send(REQ_INDEX, '0, 10'd3);
        send(REQ_ENTRY, '0, 10'd1);
        send(REQ_ENTRY, '0, 10'd2);
        send(REQ_INDEX, '0, '1);
        send(REQ_LOAD, 64'h8000_0000_0000_0001, '0);
        send(REQ_INDEX, '0, '0);

        // label table full, then point store full
        send(REQ_CLEAR, '0, '0);
        for (int i = 0; i < 65; i++) send(REQ_LOAD, {32'(i), $urandom}, '0);
        send(REQ_FINISH, '0, '0);
        send(REQ_ENTRY, '0, 10'd63);
        send(REQ_ENTRY, '0, 10'd64);
        send(REQ_CLEAR, '0, '0);
        for (int i = 0; i < 1026; i++) send(REQ_LOAD, pick_label(4), '0);
        send(REQ_FINISH, '0, '0);
        send(REQ_INDEX, '0, '1);
        send(REQ_ENTRY, '0, 10'd3);

        quiet_phase = 1'b1;
        repeat (10) run_set(20, 8, 12);
        quiet_phase = 1'b0;
        while (n_sent < 1900) begin
            if ($urandom_range(9) == 0)
                send(3'($urandom), rand64(), 10'($urandom));
            else
                run_set($urandom_range(20), $urandom_range(1, 16), $urandom_range(12));
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d results checked, %0d mismatches",
                 n_sent, sb.checked, sb.errors);
        $display("includes empty set, full label table, full point store, range errors");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
